[sv/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants of the JSON string unescaper
// Escape modes, character codes, UTF-8 encoding constants and the decoded
// item that the front end hands to the output side.
// ----------------------------------------------------------------------------
package jsu_pkg;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_ESC,
      MODE_HEX
   } mode_type;

   localparam int MAX_RESULTS = 3;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_F         = 8'h66;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_0         = 8'h30;
   localparam logic [7:0] CHAR_9         = 8'h39;
   localparam logic [7:0] CHAR_LA        = 8'h61;
   localparam logic [7:0] CHAR_LF        = 8'h66;
   localparam logic [7:0] CHAR_UA        = 8'h41;
   localparam logic [7:0] CHAR_UF        = 8'h46;

   localparam logic [7:0] CTRL_BS = 8'h08;
   localparam logic [7:0] CTRL_FF = 8'h0C;
   localparam logic [7:0] CTRL_LF = 8'h0A;
   localparam logic [7:0] CTRL_CR = 8'h0D;
   localparam logic [7:0] CTRL_HT = 8'h09;

   localparam logic [7:0]  UTF8_LEAD2     = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3     = 8'hE0;
   localparam logic [7:0]  UTF8_CONT      = 8'h80;
   localparam logic [5:0]  UTF8_CONT_MASK = 6'h3F;
   localparam logic [15:0] UTF8_ONE_LIMIT = 16'h0080;
   localparam logic [15:0] UTF8_TWO_LIMIT = 16'h0800;

   // one decoded item: up to three output bytes, with end-of-string flag
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] bytes;
      logic [1:0]                  count;
      logic                        last;
   } cmd_type;

endpackage

[sv/jsu_req_if.sv]
// ----------------------------------------------------------------------------
// jsu_req_if: raw string byte channel
// Valid/ready channel carrying one escaped byte and its end-of-string flag.
// ----------------------------------------------------------------------------
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

[sv/jsu_rsp_if.sv]
// ----------------------------------------------------------------------------
// jsu_rsp_if: decoded UTF-8 byte channel
// Valid/ready channel carrying one decoded byte, its data flag and end flag.
// ----------------------------------------------------------------------------
interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output has_byte, output out_last,
                   input ready);
   modport sink (input valid, input out_byte, input has_byte, input out_last,
                 output ready);
endinterface

[sv/json_string_unescape_utf8.sv]
// ----------------------------------------------------------------------------
// json_string_unescape_utf8: JSON string body unescaper with UTF-8 output
// Decodes escapes and \u code points of a JSON string body into UTF-8 bytes.
// ----------------------------------------------------------------------------
// One raw byte is accepted per cycle while the queue has room. Each item
// yields zero to three result bytes, which leave the output register one per
// cycle while the output is ready; a \u escape that encodes to three bytes
// yields three results. The decoder keeps taking items while the output
// drains, until the QUEUE_DEPTH-entry queue of decoded items fills; the output
// handshake alone then sets the input rate. A string whose final byte yields
// nothing ends with one empty marker result (has_byte low, out_last high).
module json_string_unescape_utf8
   import jsu_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   jsu_req_if.sink   req_chan,
   jsu_rsp_if.source rsp_chan
);

   logic    push;
   cmd_type push_cmd;
   logic    q_full;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   jsu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .push     (push),
      .push_cmd (push_cmd)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

[sv/jsu_front.sv]
// ----------------------------------------------------------------------------
// jsu_front: escape decoder
// Accepts raw bytes, tracks escape state and turns each item into a decoded
// item of zero to three bytes for the queue.
// ----------------------------------------------------------------------------
module jsu_front
   import jsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   jsu_req_if.sink     req_chan,
   input  logic        q_full,
   output logic        push,
   output cmd_type     push_cmd
);

   mode_type    mode_ff, mode_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [15:0] code_ff, code_in;
   logic        prefix_ff, prefix_in;
   logic [7:0]  pending_ff [3];

   logic        accept;
   logic [7:0]  b;
   logic        last;
   logic        dig_ok;
   logic [3:0]  dig;
   logic [15:0] code_next;
   logic [7:0]  tmp [3];

   function automatic logic [7:0] map_escape(input logic [7:0] c);
      logic [7:0] r;
      unique case (c)
         CHAR_B:  r = CTRL_BS;
         CHAR_F:  r = CTRL_FF;
         CHAR_N:  r = CTRL_LF;
         CHAR_R:  r = CTRL_CR;
         CHAR_T:  r = CTRL_HT;
         default: r = c;
      endcase
      return r;
   endfunction

   assign b      = req_chan.in_byte;
   assign last   = req_chan.in_last;
   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !q_full;

   always_comb begin
      dig_ok = 1'b1;
      dig    = 4'd0;
      if (b >= CHAR_0 && b <= CHAR_9) begin
         dig = 4'(b - CHAR_0);
      end else if (b >= CHAR_LA && b <= CHAR_LF) begin
         dig = 4'(b - CHAR_LA + 8'd10);
      end else if (b >= CHAR_UA && b <= CHAR_UF) begin
         dig = 4'(b - CHAR_UA + 8'd10);
      end else begin
         dig_ok = 1'b0;
      end
   end

   assign code_next = (prefix_ff && dig_ok) ? {code_ff[11:0], dig} : code_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         tmp[j] = (2'(j) == hex_count_ff) ? b : pending_ff[j];
      end
   end

   always_comb begin
      mode_in      = mode_ff;
      hex_count_in = hex_count_ff;
      code_in      = code_ff;
      prefix_in    = prefix_ff;
      unique case (mode_ff)
         MODE_IDLE: begin
            if (b == CHAR_BACKSLASH && !last) mode_in = MODE_ESC;
         end
         MODE_ESC: begin
            if (b == CHAR_U) begin
               mode_in      = MODE_HEX;
               hex_count_in = 2'd0;
               code_in      = 16'd0;
               prefix_in    = 1'b1;
            end else begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_HEX: begin
            code_in   = code_next;
            prefix_in = prefix_ff && dig_ok;
            if (hex_count_ff == 2'd3) begin
               mode_in      = MODE_IDLE;
               hex_count_in = 2'd0;
            end else begin
               hex_count_in = hex_count_ff + 2'd1;
            end
         end
         default: mode_in = MODE_IDLE;
      endcase
      if (last) begin
         mode_in      = MODE_IDLE;
         hex_count_in = 2'd0;
         code_in      = 16'd0;
         prefix_in    = 1'b1;
      end
   end

   always_comb begin
      push_cmd.bytes = '0;
      push_cmd.count = 2'd0;
      push_cmd.last  = last;
      unique case (mode_ff)
         MODE_IDLE: begin
            if (!(b == CHAR_BACKSLASH && !last)) begin
               push_cmd.bytes[0] = b;
               push_cmd.count    = 2'd1;
            end
         end
         MODE_ESC: begin
            if (b != CHAR_U) begin
               push_cmd.bytes[0] = map_escape(b);
               push_cmd.count    = 2'd1;
            end
         end
         MODE_HEX: begin
            if (hex_count_ff == 2'd3) begin
               if (code_next < UTF8_ONE_LIMIT) begin
                  push_cmd.bytes[0] = code_next[7:0];
                  push_cmd.count    = 2'd1;
               end else if (code_next < UTF8_TWO_LIMIT) begin
                  push_cmd.bytes[0] = UTF8_LEAD2 | {3'd0, code_next[10:6]};
                  push_cmd.bytes[1] = UTF8_CONT | {2'd0, code_next[5:0] & UTF8_CONT_MASK};
                  push_cmd.count    = 2'd2;
               end else begin
                  push_cmd.bytes[0] = UTF8_LEAD3 | {4'd0, code_next[15:12]};
                  push_cmd.bytes[1] = UTF8_CONT | {2'd0, code_next[11:6] & UTF8_CONT_MASK};
                  push_cmd.bytes[2] = UTF8_CONT | {2'd0, code_next[5:0] & UTF8_CONT_MASK};
                  push_cmd.count    = 2'd3;
               end
            end else if (last) begin
               // string ended inside a short \u: drop it, decode held bytes
               priority case (hex_count_ff)
                  2'd0: begin
                     push_cmd.bytes[0] = tmp[0];
                     push_cmd.count    = 2'd1;
                  end
                  2'd1: begin
                     if (tmp[0] == CHAR_BACKSLASH) begin
                        if (tmp[1] != CHAR_U) begin
                           push_cmd.bytes[0] = map_escape(tmp[1]);
                           push_cmd.count    = 2'd1;
                        end
                     end else begin
                        push_cmd.bytes[0] = tmp[0];
                        push_cmd.bytes[1] = tmp[1];
                        push_cmd.count    = 2'd2;
                     end
                  end
                  default: begin
                     if (tmp[0] == CHAR_BACKSLASH) begin
                        if (tmp[1] != CHAR_U) begin
                           push_cmd.bytes[0] = map_escape(tmp[1]);
                           push_cmd.bytes[1] = tmp[2];
                           push_cmd.count    = 2'd2;
                        end else begin
                           push_cmd.bytes[0] = tmp[2];
                           push_cmd.count    = 2'd1;
                        end
                     end else if (tmp[1] == CHAR_BACKSLASH) begin
                        push_cmd.bytes[0] = tmp[0];
                        if (tmp[2] != CHAR_U) begin
                           push_cmd.bytes[1] = map_escape(tmp[2]);
                           push_cmd.count    = 2'd2;
                        end else begin
                           push_cmd.count = 2'd1;
                        end
                     end else begin
                        push_cmd.bytes[0] = tmp[0];
                        push_cmd.bytes[1] = tmp[1];
                        push_cmd.bytes[2] = tmp[2];
                        push_cmd.count    = 2'd3;
                     end
                  end
               endcase
            end
         end
         default: push_cmd.count = 2'd0;
      endcase
   end

   assign push = accept && (push_cmd.count != 2'd0 || last);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         hex_count_ff <= 2'd0;
         code_ff      <= 16'd0;
         prefix_ff    <= 1'b1;
      end else if (accept) begin
         mode_ff      <= mode_in;
         hex_count_ff <= hex_count_in;
         code_ff      <= code_in;
         prefix_ff    <= prefix_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && mode_ff == MODE_HEX && hex_count_ff != 2'd3 && !last) begin
         pending_ff[hex_count_ff] <= b;
      end
   end

`ifndef SYNTHESIS
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && last |=> mode_ff == MODE_IDLE && hex_count_ff == 2'd0 && prefix_ff)
      else $error("state not cleared after end of string");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("push into full queue");
`endif

endmodule

[sv/jsu_queue.sv]
// ----------------------------------------------------------------------------
// jsu_queue: decoded item queue
// Short FIFO of decoded items between the escape decoder and the output side.
// ----------------------------------------------------------------------------
module jsu_queue
   import jsu_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_pop;

   assign full       = count_ff == CNT_W'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !do_pop) count_ff <= count_ff + 1'b1;
         else if (!push && do_pop) count_ff <= count_ff - 1'b1;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count out of range");
`endif

endmodule

[sv/jsu_back.sv]
// ----------------------------------------------------------------------------
// jsu_back: output sequencer
// Walks the head item bytes into the output register one per unstalled cycle.
// ----------------------------------------------------------------------------
module jsu_back
   import jsu_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   input  cmd_type   head_cmd,
   output logic      pop,
   jsu_rsp_if.source rsp_chan
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       has_ff, has_in;
   logic       last_ff, last_in;
   logic       load;
   logic       final_byte;

   assign load       = !valid_ff || rsp_chan.ready;
   assign final_byte = head_cmd.count == 2'd0 || idx_ff == head_cmd.count - 2'd1;
   assign pop        = load && head_valid && final_byte;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      has_in   = has_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = head_valid;
         has_in   = head_cmd.count != 2'd0;
         byte_in  = (head_cmd.count != 2'd0) ? head_cmd.bytes[idx_ff] : 8'd0;
         last_in  = head_cmd.last && final_byte;
         if (head_valid) idx_in = final_byte ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      has_ff  <= has_in;
      last_ff <= last_in;
   end

   assign rsp_chan.valid    = valid_ff;
   assign rsp_chan.out_byte = byte_ff;
   assign rsp_chan.has_byte = has_ff;
   assign rsp_chan.out_last = last_ff;

`ifndef SYNTHESIS
   a_marker_form: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !has_ff |-> last_ff && byte_ff == 8'd0)
      else $error("empty result that is not an end marker");
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      head_valid && head_cmd.count != 2'd0 |-> idx_ff < head_cmd.count)
      else $error("byte index past item length");
`endif

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench of the JSON string unescaper
// Streams escaped string bodies into the block with random gaps and output
// stalls, decodes each accepted byte in a local model of the unescaper and
// compares every decoded UTF-8 item, field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
   import jsu_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       has_byte;
      logic       last;
   } utf8_beat_type;

   logic clock = 1'b0;
   logic reset;
   logic idling;
   int unsigned failures = 0;
   int unsigned hold_cnt = 0;

   utf8_beat_type utf8_due [$];
   logic [7:0] step_bytes [$];

   mode_type    esc_state;
   logic [1:0]  held_count;
   logic [7:0]  held_chars [3];
   logic [15:0] code_acc;
   logic        prefix_live;

   jsu_req_if req_bus ();
   jsu_rsp_if rsp_bus ();

   json_string_unescape_utf8 dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] escape_char(input logic [7:0] c);
      case (c)
         CHAR_B: return CTRL_BS;
         CHAR_F: return CTRL_FF;
         CHAR_N: return CTRL_LF;
         CHAR_R: return CTRL_CR;
         CHAR_T: return CTRL_HT;
         default: return c;
      endcase
   endfunction

   function automatic int hex_value(input logic [7:0] c);
      if (c >= CHAR_0 && c <= CHAR_9) return int'(c - CHAR_0);
      if (c >= CHAR_LA && c <= CHAR_LF) return int'(c - CHAR_LA) + 10;
      if (c >= CHAR_UA && c <= CHAR_UF) return int'(c - CHAR_UA) + 10;
      return -1;
   endfunction

   function automatic void put_decoded(input logic [7:0] b);
      if (step_bytes.size() < MAX_RESULTS) step_bytes.push_back(b);
   endfunction

   task automatic clear_decoder();
      esc_state   = MODE_IDLE;
      held_count  = 2'd0;
      code_acc    = 16'h0000;
      prefix_live = 1'b1;
   endtask

   task automatic unescape_step(input logic [7:0] b, input logic l);
      int d;
      int i;
      logic [7:0] held [$];
      step_bytes = {};
      case (esc_state)
         MODE_ESC: begin
            if (b == CHAR_U) begin
               esc_state   = MODE_HEX;
               held_count  = 2'd0;
               code_acc    = 16'h0000;
               prefix_live = 1'b1;
            end else begin
               put_decoded(escape_char(b));
               esc_state = MODE_IDLE;
            end
         end
         MODE_HEX: begin
            d = hex_value(b);
            if (prefix_live && d >= 0) code_acc = {code_acc[11:0], d[3:0]};
            else prefix_live = 1'b0;
            if (held_count == 2'd3) begin
               if (code_acc < UTF8_ONE_LIMIT) begin
                  put_decoded(code_acc[7:0]);
               end else if (code_acc < UTF8_TWO_LIMIT) begin
                  put_decoded(UTF8_LEAD2 | {3'b000, code_acc[10:6]});
                  put_decoded(UTF8_CONT | {2'b00, code_acc[5:0] & UTF8_CONT_MASK});
               end else begin
                  put_decoded(UTF8_LEAD3 | {4'h0, code_acc[15:12]});
                  put_decoded(UTF8_CONT | {2'b00, code_acc[11:6] & UTF8_CONT_MASK});
                  put_decoded(UTF8_CONT | {2'b00, code_acc[5:0] & UTF8_CONT_MASK});
               end
               esc_state  = MODE_IDLE;
               held_count = 2'd0;
            end else if (l) begin
               // drop the short \u, decode what it held, with any escapes in it
               for (i = 0; i < held_count; i++) held.push_back(held_chars[i]);
               held.push_back(b);
               i = 0;
               while (i < held.size()) begin
                  if (held[i] == CHAR_BACKSLASH && i + 1 < held.size()) begin
                     if (held[i+1] != CHAR_U) put_decoded(escape_char(held[i+1]));
                     i += 2;
                  end else begin
                     put_decoded(held[i]);
                     i++;
                  end
               end
            end else begin
               held_chars[held_count] = b;
               held_count++;
            end
         end
         default: begin
            if (b == CHAR_BACKSLASH && !l) esc_state = MODE_ESC;
            else put_decoded(b);
         end
      endcase
      if (l && step_bytes.size() == 0) utf8_due.push_back('{8'h00, 1'b0, 1'b1});
      foreach (step_bytes[j])
         utf8_due.push_back('{step_bytes[j], 1'b1, l && (j == step_bytes.size() - 1)});
      if (l) clear_decoder();
   endtask

   task automatic send_item(input logic [7:0] b, input logic l);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= b;
      req_bus.in_last <= l;
      do @(posedge clock); while (!req_bus.ready);
      unescape_step(b, l);
   endtask

   task automatic send_string(input logic [7:0] text [$]);
      foreach (text[i]) send_item(text[i], i == text.size() - 1);
   endtask

   task automatic send_text(input string s);
      logic [7:0] text [$];
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
      send_string(text);
   endtask

   task automatic test_plain_extremes();
      send_string({8'h00, 8'hFF});
   endtask

   task automatic test_simple_escapes();
      send_text("\\b\\f\\n\\r\\t\\\\\\q");
   endtask

   task automatic test_unicode();
      send_text("\\u20AC\\ue9z!");
   endtask

   task automatic test_string_end_cases();
      send_text("\\");
      send_text("\\u4\\n");
      send_text("\\u");
   endtask

   task automatic test_random_strings(input int unsigned item_goal);
      logic [7:0] text [$];
      string hex_set;
      string esc_set;
      int unsigned sent;
      int unsigned target;
      int unsigned zeros;
      hex_set = "0123456789abcdefABCDEF";
      esc_set = "bfnrt\"\\/u";
      sent = 0;
      while (sent < item_goal) begin
         text = {};
         target = $urandom_range(1, 12);
         while (text.size() < target) begin
            case ($urandom_range(0, 9))
               0, 1: text.push_back(8'($urandom_range(0, 255)));
               2, 3, 4: begin
                  text.push_back(CHAR_BACKSLASH);
                  if ($urandom_range(0, 4) == 0) text.push_back(8'($urandom_range(0, 255)));
                  else text.push_back(esc_set[$urandom_range(0, esc_set.len() - 1)]);
               end
               default: begin
                  text.push_back(CHAR_BACKSLASH);
                  text.push_back(CHAR_U);
                  zeros = $urandom_range(0, 2);
                  for (int k = 0; k < 4; k++) begin
                     if (k < zeros) text.push_back(CHAR_0);
                     else if ($urandom_range(0, 9) == 0)
                        text.push_back(8'($urandom_range(0, 255)));
                     else text.push_back(hex_set[$urandom_range(0, hex_set.len() - 1)]);
                  end
               end
            endcase
         end
         if ($urandom_range(0, 3) == 0)
            while (text.size() > target) void'(text.pop_back());
         sent += text.size();
         send_string(text);
      end
   endtask

   always @(posedge clock) begin
      if (hold_cnt == 0 && idling && $urandom_range(0, 4) == 0)
         hold_cnt = $urandom_range(1, 7);
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      utf8_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (utf8_due.size() == 0) begin
            $display("%0t: unexpected item: expected none, got byte %h has %b last %b",
                     $time, rsp_bus.out_byte, rsp_bus.has_byte, rsp_bus.out_last);
            failures++;
         end else begin
            want = utf8_due.pop_front();
            if (rsp_bus.out_byte !== want.data) begin
               $display("%0t: out_byte expected %h got %h", $time, want.data, rsp_bus.out_byte);
               failures++;
            end
            if (rsp_bus.has_byte !== want.has_byte) begin
               $display("%0t: has_byte expected %b got %b",
                        $time, want.has_byte, rsp_bus.has_byte);
               failures++;
            end
            if (rsp_bus.out_last !== want.last) begin
               $display("%0t: out_last expected %b got %b", $time, want.last, rsp_bus.out_last);
               failures++;
            end
         end
      end
   end

   initial begin
      #1_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int unsigned waited;
      reset           = 1'b1;
      idling          = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.in_byte = 8'h00;
      req_bus.in_last = 1'b0;
      rsp_bus.ready   = 1'b0;
      clear_decoder();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_plain_extremes();
      test_simple_escapes();
      test_unicode();
      test_string_end_cases();
      test_random_strings(60);
      idling = 1'b0;
      test_random_strings(20);
      req_bus.valid <= 1'b0;

      waited = 0;
      while (utf8_due.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (utf8_due.size() != 0) begin
         $display("%0t: %0d items still expected, none arrived", $time, utf8_due.size());
         failures++;
      end
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[files.f]
sv/jsu_pkg.sv
sv/jsu_req_if.sv
sv/jsu_rsp_if.sv
sv/jsu_front.sv
sv/jsu_queue.sv
sv/jsu_back.sv
sv/json_string_unescape_utf8.sv
tb/tb_top.sv
